// ===== sv/sppd_pkg.sv =====
`default_nettype none

package sppd_pkg;

    // Register fields and their widths.
    localparam int DELAY_W = 33;
    localparam int GAIN_W  = 16;
    localparam int MIX_W   = 17;
    localparam int FRAC_W  = 16;

    // Register indexes on the configuration port.
    localparam logic [1:0] REG_TARGET = 2'd0;
    localparam logic [1:0] REG_GAIN   = 2'd1;
    localparam logic [1:0] REG_MIX    = 2'd2;

    // Feedback gain cap (0.95 in Q0.16) and the full wet share (1.0 in Q1.16).
    localparam logic [GAIN_W-1:0] GAIN_CAP = 16'd62259;
    localparam logic [MIX_W-1:0]  MIX_FULL = 17'd65536;

    // Multiply steps of the shared multiply-accumulate unit.
    localparam logic [3:0] STEP_L_TAP1   = 4'd0;
    localparam logic [3:0] STEP_L_TAP2   = 4'd1;
    localparam logic [3:0] STEP_R_TAP1   = 4'd2;
    localparam logic [3:0] STEP_R_TAP2   = 4'd3;
    localparam logic [3:0] STEP_L_DRY    = 4'd4;
    localparam logic [3:0] STEP_L_WET    = 4'd5;
    localparam logic [3:0] STEP_R_DRY    = 4'd6;
    localparam logic [3:0] STEP_R_WET    = 4'd7;
    localparam logic [3:0] STEP_L_FB     = 4'd8;
    localparam logic [3:0] STEP_R_FB     = 4'd9;
    localparam logic [3:0] STEP_DRAIN    = 4'd10;

    // Sequencer states.
    typedef enum logic [8:0] {
        S_IDLE = 9'b000000001,
        S_DIFF = 9'b000000010,
        S_UPD  = 9'b000000100,
        S_RD1  = 9'b000001000,
        S_RD2  = 9'b000010000,
        S_CAP  = 9'b000100000,
        S_MAC  = 9'b001000000,
        S_WR   = 9'b010000000,
        S_OUT  = 9'b100000000
    } t_state;

endpackage

`default_nettype wire

// ===== sv/sppd_ram.sv =====
`default_nettype none

module sppd_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 131072
) (
    input  wire                       i_clk,
    input  wire                       i_we,
    input  wire [$clog2(DEPTH)-1:0]   i_addr,
    input  wire [WIDTH-1:0]           i_wdata,
    output logic [WIDTH-1:0]          o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Single port: write or registered read at one address per cycle.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== sv/stereo_ping_pong_delay.sv =====
// A processed pair enters the output register at the end of processing, once the output
// slot is free; a bypassed pair (target and current delay both under one sample) appears
// on the next cycle. A new pair is taken only in IDLE, and each needs ten products through
// the single shared multiplier and two reads plus one write through each single-port delay
// store. Reset (synchronous, active low) clears the control and configuration registers,
// then sweeps both stores to zero, taking no request meanwhile; configuration still works.
`default_nettype none

module stereo_ping_pong_delay #(
    parameter int STORE_DEPTH  = 131072,
    parameter int SAMPLE_WIDTH = 24
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    // Input stream. tdata: left_in, right_in (from the lowest bit up).
    input  wire                 s_axis_tvalid,
    output logic                s_axis_tready,
    input  wire [((2*SAMPLE_WIDTH+7)/8)*8-1:0] s_axis_tdata,
    // Output stream. tdata: left_out, right_out (from the lowest bit up).
    output logic                m_axis_tvalid,
    input  wire                 m_axis_tready,
    output logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0] m_axis_tdata,
    // Configuration port.
    input  wire                 psel,
    input  wire                 penable,
    input  wire                 pwrite,
    input  wire [4:0]           paddr,
    input  wire [63:0]          pwdata,
    output logic [63:0]         prdata,
    output logic                pready
);

    localparam int SW = SAMPLE_WIDTH;
    localparam int AW = $clog2(STORE_DEPTH);
    localparam int PW = AW + sppd_pkg::FRAC_W;
    localparam int DW = ((2*SAMPLE_WIDTH+7)/8)*8;
    localparam int PRW = SW + 18;
    localparam int ACW = SW + 19;
    localparam int FW  = SW + 3;

    // Configuration registers.
    logic [sppd_pkg::DELAY_W-1:0] r_target;
    logic [sppd_pkg::GAIN_W-1:0]  r_gain;
    logic [sppd_pkg::MIX_W-1:0]   r_mix;
    logic [sppd_pkg::DELAY_W-1:0] r_cur;

    // Sequencer and datapath registers.
    sppd_pkg::t_state r_state;
    logic                 r_clearing;
    logic [AW-1:0]        r_clr_addr;
    logic [AW-1:0]        r_wp;
    logic [AW-1:0]        r_i1;
    logic [15:0]          r_fr;
    logic signed [40:0]   r_d66;
    logic signed [SW-1:0] r_xl, r_xr;
    logic signed [SW-1:0] r_s1l, r_s1r, r_s2l, r_s2r;
    logic signed [SW-1:0] r_dl, r_dr;
    logic signed [SW-1:0] r_wl, r_wr;
    logic signed [SW-1:0] r_ol, r_or;
    logic [3:0]           r_step;
    logic [3:0]           r_pstep;
    logic                 r_pvalid;
    logic signed [PRW-1:0] r_prod;
    logic signed [ACW-1:0] r_acc;
    logic                 r_o_valid;
    logic signed [SW-1:0] r_o_left, r_o_right;

    logic                 w_cfg_wr;
    logic                 w_bypass;
    logic                 w_in_acc;
    logic                 w_slot_free;
    logic signed [SW-1:0] w_in_l, w_in_r;
    logic signed [33:0]   w_diff;
    logic signed [24:0]   w_step;
    logic [33:0]          w_cur_sum;
    logic [PW+32:0]       w_pos_full;
    logic [PW-1:0]        w_pos;
    logic [sppd_pkg::GAIN_W-1:0] w_gain;
    logic [sppd_pkg::MIX_W-1:0]  w_mix;
    logic signed [17:0]   w_w1, w_w2, w_dry, w_wet, w_g;
    logic signed [SW-1:0] w_a;
    logic signed [17:0]   w_b;
    logic signed [PRW-1:0] w_prod;
    logic                 w_add;
    logic signed [ACW-1:0] w_sum;
    logic signed [FW-1:0] w_fin;
    logic                 w_we;
    logic [AW-1:0]        w_addr;
    logic [SW-1:0]        w_wdata_l, w_wdata_r;
    logic [SW-1:0]        w_rdata_l, w_rdata_r;

    // Saturate to the signed sample range.
    function automatic logic signed [SW-1:0] sat(input logic signed [SW+3:0] v);
        logic signed [SW+3:0] hi;
        logic signed [SW+3:0] lo;
        hi = (SW+4)'((65'sd1 <<< (SW-1)) - 65'sd1);
        lo = -hi - (SW+4)'(1);
        if (v > hi) begin
            sat = hi[SW-1:0];
        end else if (v < lo) begin
            sat = lo[SW-1:0];
        end else begin
            sat = v[SW-1:0];
        end
    endfunction

    assign w_in_l = s_axis_tdata[SW-1:0];
    assign w_in_r = s_axis_tdata[2*SW-1:SW];

    // Configuration port.
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_comb begin
        case (paddr[4:3])
            sppd_pkg::REG_TARGET: prdata = 64'(r_target);
            sppd_pkg::REG_GAIN:   prdata = 64'(r_gain);
            sppd_pkg::REG_MIX:    prdata = 64'(r_mix);
            default:              prdata = 64'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target <= '0;
            r_gain   <= '0;
            r_mix    <= '0;
        end else if (w_cfg_wr) begin
            case (paddr[4:3])
                sppd_pkg::REG_TARGET: r_target <= pwdata[sppd_pkg::DELAY_W-1:0];
                sppd_pkg::REG_GAIN:   r_gain   <= pwdata[sppd_pkg::GAIN_W-1:0];
                sppd_pkg::REG_MIX:    r_mix    <= pwdata[sppd_pkg::MIX_W-1:0];
                default: ;
            endcase
        end
    end

    // Bypass when both target and current delay are under one sample.
    assign w_bypass    = (r_target[32:16] == '0) && (r_cur[32:16] == '0);
    assign w_slot_free = !r_o_valid || m_axis_tready;
    assign s_axis_tready = (r_state == sppd_pkg::S_IDLE) && !r_clearing
                           && (!w_bypass || w_slot_free);
    assign w_in_acc = s_axis_tvalid && s_axis_tready;

    // Delay smoothing: step = floor((target - current) * 66 / 65536).
    assign w_diff = $signed({1'b0, r_target}) - $signed({1'b0, r_cur});
    assign w_step = r_d66[40:16];
    assign w_cur_sum = {1'b0, r_cur} + {{9{w_step[24]}}, w_step};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur <= '0;
        end else if (r_state == sppd_pkg::S_UPD) begin
            r_cur <= w_cur_sum[sppd_pkg::DELAY_W-1:0];
        end else if (w_cfg_wr && paddr[4:3] == sppd_pkg::REG_TARGET && r_cur == '0) begin
            r_cur <= pwdata[sppd_pkg::DELAY_W-1:0];
        end
    end

    // Read position, wrapped to the store length.
    assign w_pos_full = {33'd0, r_wp, 16'd0} - {{PW{1'b0}}, r_cur};
    assign w_pos      = w_pos_full[PW-1:0];

    // Clamped gain and mix, and the weights of each multiply step.
    assign w_gain = (r_gain > sppd_pkg::GAIN_CAP) ? sppd_pkg::GAIN_CAP : r_gain;
    assign w_mix  = (r_mix > sppd_pkg::MIX_FULL) ? sppd_pkg::MIX_FULL : r_mix;
    assign w_w2   = $signed({2'b00, r_fr});
    assign w_w1   = 18'sd65536 - w_w2;
    assign w_wet  = $signed({1'b0, w_mix});
    assign w_dry  = 18'sd65536 - w_wet;
    assign w_g    = $signed({2'b00, w_gain});

    always_comb begin
        case (r_step)
            sppd_pkg::STEP_L_TAP1: begin w_a = r_s1l; w_b = w_w1;  end
            sppd_pkg::STEP_L_TAP2: begin w_a = r_s2l; w_b = w_w2;  end
            sppd_pkg::STEP_R_TAP1: begin w_a = r_s1r; w_b = w_w1;  end
            sppd_pkg::STEP_R_TAP2: begin w_a = r_s2r; w_b = w_w2;  end
            sppd_pkg::STEP_L_DRY:  begin w_a = r_xl;  w_b = w_dry; end
            sppd_pkg::STEP_L_WET:  begin w_a = r_dl;  w_b = w_wet; end
            sppd_pkg::STEP_R_DRY:  begin w_a = r_xr;  w_b = w_dry; end
            sppd_pkg::STEP_R_WET:  begin w_a = r_dr;  w_b = w_wet; end
            sppd_pkg::STEP_L_FB:   begin w_a = r_dr;  w_b = w_g;   end
            sppd_pkg::STEP_R_FB:   begin w_a = r_dl;  w_b = w_g;   end
            default:               begin w_a = '0;    w_b = '0;    end
        endcase
    end

    assign w_prod = w_a * w_b;

    // Second product of a pair adds onto the first; feedback products stand alone.
    always_comb begin
        case (r_pstep)
            sppd_pkg::STEP_L_TAP2, sppd_pkg::STEP_R_TAP2,
            sppd_pkg::STEP_L_WET, sppd_pkg::STEP_R_WET: w_add = 1'b1;
            default:                                     w_add = 1'b0;
        endcase
    end

    assign w_sum = (w_add ? r_acc : '0) + ACW'(r_prod);
    assign w_fin = w_sum[ACW-1:16];

    // Store port control: clearing sweep, tap reads, then the write-back.
    always_comb begin
        w_we      = 1'b0;
        w_addr    = r_wp;
        w_wdata_l = r_wl;
        w_wdata_r = r_wr;
        if (r_clearing) begin
            w_we      = 1'b1;
            w_addr    = r_clr_addr;
            w_wdata_l = '0;
            w_wdata_r = '0;
        end else begin
            case (r_state)
                sppd_pkg::S_RD1: w_addr = w_pos[PW-1:16];
                sppd_pkg::S_RD2: w_addr = r_i1 + AW'(1);
                sppd_pkg::S_WR:  w_we   = 1'b1;
                default: ;
            endcase
        end
    end

    sppd_ram #(.WIDTH(SW), .DEPTH(STORE_DEPTH)) u_left_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_addr  (w_addr),
        .i_wdata (w_wdata_l),
        .o_rdata (w_rdata_l)
    );

    sppd_ram #(.WIDTH(SW), .DEPTH(STORE_DEPTH)) u_right_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_addr  (w_addr),
        .i_wdata (w_wdata_r),
        .o_rdata (w_rdata_r)
    );

    // Sequencer control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= sppd_pkg::S_IDLE;
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
            r_wp       <= '0;
            r_step     <= sppd_pkg::STEP_L_TAP1;
            r_pvalid   <= 1'b0;
        end else begin
            if (r_clearing) begin
                r_clr_addr <= r_clr_addr + AW'(1);
                if (r_clr_addr == '1) begin
                    r_clearing <= 1'b0;
                end
            end
            r_pvalid <= (r_state == sppd_pkg::S_MAC) && (r_step != sppd_pkg::STEP_DRAIN);
            case (r_state)
                sppd_pkg::S_IDLE: begin
                    if (w_in_acc && !w_bypass) begin
                        r_state <= sppd_pkg::S_DIFF;
                    end
                end
                sppd_pkg::S_DIFF: r_state <= sppd_pkg::S_UPD;
                sppd_pkg::S_UPD:  r_state <= sppd_pkg::S_RD1;
                sppd_pkg::S_RD1:  r_state <= sppd_pkg::S_RD2;
                sppd_pkg::S_RD2:  r_state <= sppd_pkg::S_CAP;
                sppd_pkg::S_CAP: begin
                    r_step  <= sppd_pkg::STEP_L_TAP1;
                    r_state <= sppd_pkg::S_MAC;
                end
                sppd_pkg::S_MAC: begin
                    if (r_step == sppd_pkg::STEP_DRAIN) begin
                        r_step  <= sppd_pkg::STEP_L_TAP1;
                        r_state <= sppd_pkg::S_WR;
                    end else begin
                        r_step <= r_step + 4'd1;
                    end
                end
                sppd_pkg::S_WR: begin
                    r_wp    <= r_wp + AW'(1);
                    r_state <= sppd_pkg::S_OUT;
                end
                sppd_pkg::S_OUT: begin
                    if (w_slot_free) begin
                        r_state <= sppd_pkg::S_IDLE;
                    end
                end
                default: r_state <= sppd_pkg::S_IDLE;
            endcase
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_xl <= w_in_l;
            r_xr <= w_in_r;
        end
        if (r_state == sppd_pkg::S_DIFF) begin
            // Times 66 as times 64 plus times 2.
            r_d66 <= ({{7{w_diff[33]}}, w_diff} <<< 6) + ({{7{w_diff[33]}}, w_diff} <<< 1);
        end
        if (r_state == sppd_pkg::S_RD1) begin
            r_i1 <= w_pos[PW-1:16];
            r_fr <= w_pos[15:0];
        end
        if (r_state == sppd_pkg::S_RD2) begin
            r_s1l <= w_rdata_l;
            r_s1r <= w_rdata_r;
        end
        if (r_state == sppd_pkg::S_CAP) begin
            r_s2l <= w_rdata_l;
            r_s2r <= w_rdata_r;
        end
        r_prod  <= w_prod;
        r_pstep <= r_step;
        if (r_pvalid) begin
            case (r_pstep)
                sppd_pkg::STEP_L_TAP1, sppd_pkg::STEP_R_TAP1,
                sppd_pkg::STEP_L_DRY, sppd_pkg::STEP_R_DRY: r_acc <= ACW'(r_prod);
                sppd_pkg::STEP_L_TAP2: r_dl <= w_fin[SW-1:0];
                sppd_pkg::STEP_R_TAP2: r_dr <= w_fin[SW-1:0];
                sppd_pkg::STEP_L_WET:  r_ol <= sat((SW+4)'(w_fin));
                sppd_pkg::STEP_R_WET:  r_or <= sat((SW+4)'(w_fin));
                sppd_pkg::STEP_L_FB:   r_wl <= sat((SW+4)'(w_fin) + (SW+4)'(r_xl));
                sppd_pkg::STEP_R_FB:   r_wr <= sat((SW+4)'(w_fin) + (SW+4)'(r_xr));
                default: ;
            endcase
        end
    end

    // Output register: loaded by a bypassed request or at the end of processing.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (w_in_acc && w_bypass) begin
            r_o_valid <= 1'b1;
        end else if (r_state == sppd_pkg::S_OUT && w_slot_free) begin
            r_o_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc && w_bypass) begin
            r_o_left  <= w_in_l;
            r_o_right <= w_in_r;
        end else if (r_state == sppd_pkg::S_OUT && w_slot_free) begin
            r_o_left  <= r_ol;
            r_o_right <= r_or;
        end
    end

    assign m_axis_tvalid = r_o_valid;
    assign m_axis_tdata  = DW'({r_o_right, r_o_left});

endmodule

`default_nettype wire
